// ----- hw/rtl/bht_pkg.sv -----
// ============================================================================
// bht_pkg
// Shared types, sizes and helpers for the breakpoint hash table.
// ============================================================================
package bht_pkg;

    localparam int BUCKETS  = 256;
    localparam int WAYS     = 4;
    localparam int ADDR_W   = 64;
    localparam int FLAGS_W  = 8;
    localparam int BUCKET_W = $clog2(BUCKETS);

    localparam logic [0:0] FUNC_LOOKUP = 1'b0;
    localparam logic [0:0] FUNC_SET    = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One bucket: every way's key and flags, stored as one memory word.
    typedef struct packed {
        logic [WAYS-1:0][ADDR_W-1:0]  keys;
        logic [WAYS-1:0][FLAGS_W-1:0] flags;
    } row_t;

    typedef struct packed {
        logic                en;
        logic [BUCKET_W-1:0] bucket;
        row_t                row;
    } wr_req_t;

    typedef struct packed {
        logic [FLAGS_W-1:0] found_flags;
        logic               status;
    } result_t;

    // The bucket keeps the low bits of the wrapping 32-bit sum of the address halves.
    // BUCKETS is a power of two.
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [ADDR_W-1:0] addr);
        logic [31:0] sum;
        begin
            sum = addr[63:32] + addr[31:0];
            bucket_of = sum[BUCKET_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/bht_row_store.sv -----
// ============================================================================
// bht_row_store
// Bucket memory with per-row valid bits and write-to-read forwarding.
// ============================================================================
module bht_row_store
    import bht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [BUCKET_W-1:0] rd_bucket,
    input  wr_req_t             wr,
    output row_t                rd_row
);

    row_t                mem [BUCKETS];
    logic [BUCKETS-1:0]  valid_reg;
    row_t                rdata_reg;
    logic                rvalid_reg;
    logic                fwd_reg;
    row_t                fwd_row_reg;
    row_t                clean_row;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.bucket] <= wr.row;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_bucket];
        end
    end

    // A row never written reads as empty. A write landing in the same cycle as a
    // read of the same row is forwarded, since the memory returns the old word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.bucket] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_bucket];
                fwd_reg    <= wr.en && (wr.bucket == rd_bucket);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_row_reg <= wr.row;
        end
    end

    always_comb
    begin
        clean_row       = rdata_reg;
        clean_row.flags = '0;
        if (fwd_reg)
        begin
            rd_row = fwd_row_reg;
        end
        else if (rvalid_reg)
        begin
            rd_row = rdata_reg;
        end
        else
        begin
            rd_row = clean_row;
        end
    end

endmodule

// ----- hw/rtl/bht_way_logic.sv -----
// ============================================================================
// bht_way_logic
// Way match, lookup result and row update for one bucket.
// ============================================================================
module bht_way_logic
    import bht_pkg::*;
(
    input  row_t               row,
    input  logic [0:0]         func,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [FLAGS_W-1:0] new_flags,
    output logic               wr_en,
    output row_t               new_row,
    output result_t            result
);

    logic [WAYS-1:0]    hit;
    logic [WAYS-1:0]    free;
    logic [WAYS-1:0]    first_free;
    logic [FLAGS_W-1:0] hit_flags;
    logic               hit_any;
    logic               free_any;
    logic               do_insert;

    always_comb
    begin
        hit_flags = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w]    = (row.flags[w] != '0) && (row.keys[w] == addr);
            free[w]   = (row.flags[w] == '0);
            hit_flags = hit_flags | (hit[w] ? row.flags[w] : '0);
        end
        hit_any  = |hit;
        free_any = |free;

        // The lowest-numbered free way takes an insert.
        first_free = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (free[w])
            begin
                first_free    = '0;
                first_free[w] = 1'b1;
            end
        end

        do_insert = (func == FUNC_SET) && !hit_any && (new_flags != '0) && free_any;
        wr_en     = ((func == FUNC_SET) && hit_any) || do_insert;

        new_row = row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit[w])
            begin
                new_row.flags[w] = new_flags;
            end
            else if (do_insert && first_free[w])
            begin
                new_row.flags[w] = new_flags;
                new_row.keys[w]  = addr;
            end
        end

        result.found_flags = (func == FUNC_LOOKUP) ? hit_flags : '0;
        result.status      = ((func == FUNC_SET) && !hit_any && (new_flags != '0) && !free_any)
                             ? STATUS_FULL : STATUS_DONE;
    end

endmodule

// ----- hw/rtl/breakpoint_hash_table.sv -----
// ============================================================================
// breakpoint_hash_table
// Set-associative table mapping 64-bit addresses to 8-bit breakpoint flags.
// ============================================================================
// Each input transaction is a lookup or a set and yields exactly one output
// transaction. The block takes one transaction per cycle while the output is
// drained. A result passes through the first-stage registers, which capture
// the input and read its bucket row at the accepting edge, and then through
// the output register, which offers it on the output. A set writes its
// updated bucket row back as it leaves the first stage, through the memory's
// single write port; a following transaction to the same bucket sees the new
// row through forwarding. Rows start empty through per-row valid bits, so there
// is no clearing pass after reset.
module breakpoint_hash_table
    import bht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // addr[63:0], new_flags[71:64]
    input  logic [0:0]  s_axis_tuser,  // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // found_flags[7:0], status[8], zero[15:9]
);

    logic                in_acc;
    logic                out_free;
    logic                s1_adv;
    logic                s1_valid_reg;
    logic [0:0]          s1_func_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [FLAGS_W-1:0]  s1_flags_reg;
    logic [BUCKET_W-1:0] s1_bucket_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;
    logic [BUCKET_W-1:0] in_bucket;
    row_t                rd_row;
    row_t                new_row;
    logic                upd_wr_en;
    result_t             result;
    wr_req_t             wr;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_bucket     = bucket_of(s_axis_tdata[ADDR_W-1:0]);

    assign wr.en     = s1_adv && upd_wr_en;
    assign wr.bucket = s1_bucket_reg;
    assign wr.row    = new_row;

    bht_row_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_acc),
        .rd_bucket (in_bucket),
        .wr        (wr),
        .rd_row    (rd_row)
    );

    bht_way_logic u_ways
    (
        .row       (rd_row),
        .func      (s1_func_reg),
        .addr      (s1_addr_reg),
        .new_flags (s1_flags_reg),
        .wr_en     (upd_wr_en),
        .new_row   (new_row),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_func_reg   <= s_axis_tuser;
            s1_addr_reg   <= s_axis_tdata[ADDR_W-1:0];
            s1_flags_reg  <= s_axis_tdata[ADDR_W+FLAGS_W-1:ADDR_W];
            s1_bucket_reg <= in_bucket;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg.status, out_data_reg.found_flags};

    // A full-bucket rejection never carries flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status) |-> (out_data_reg.found_flags == '0))
        else $error("full status reported with nonzero flags");

    // A table write only happens for a set that leaves the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (s1_adv && (s1_func_reg == FUNC_SET)))
        else $error("row written without a set leaving the pipeline");

    // An item that leaves the first stage shows up on the output next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("result lost between stage and output register");

    // Input stalls only when both stages are occupied and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without backpressure");

endmodule
